FILE: hw/rtl/bcl_pkg.sv
package bcl_pkg;

   // Field widths.
   localparam int TimeWidth = 32;
   localparam int CfgWidth  = 16;

   // Register reset values.
   localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [CfgWidth-1:0] LongPressReset = 16'd1000;
   localparam logic                PressedReset   = 1'b0;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_DEBOUNCE      = 2'd0,
      CSR_LONG_PRESS    = 2'd1,
      CSR_PRESSED_LEVEL = 2'd2
   } bcl_csr_type;

   // Event codes reported with each result item.
   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_CLICK = 2'd1,
      EVENT_LONG  = 2'd2
   } bcl_event_type;

   // Configuration handed to the detector.
   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] long_press_ms;
      logic                pressed_level;
   } bcl_cfg_type;

   // One registered input item.
   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 pin_level;
   } bcl_sample_type;

endpackage

FILE: hw/rtl/bcl_req_stage.sv
module bcl_req_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [bcl_pkg::TimeWidth-1:0] req_now_ms,
   input  logic                          req_pin_level,
   output logic                          req_stall,
   input  logic                          out_ready,
   output logic                          sample_valid,
   output bcl_pkg::bcl_sample_type       sample
);
   import bcl_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   bcl_sample_type sample_ff;
   logic           take;

   // Hold the input while the stored item cannot move on.
   assign req_stall = valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register loads only when an item is taken.
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff.now_ms    <= req_now_ms;
         sample_ff.pin_level <= req_pin_level;
      end
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

FILE: hw/rtl/bcl_detect.sv
module bcl_detect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  bcl_pkg::bcl_sample_type sample,
   input  bcl_pkg::bcl_cfg_type cfg,
   output logic [1:0]           event_code,
   output logic [1:0]           button_status
);
   import bcl_pkg::*;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_DOWN  = 2'd1,
      MODE_CLICK = 2'd2,
      MODE_LONG  = 2'd3
   } mode_type;

   logic                 primed_ff, primed_in;
   logic                 held_level_ff, held_level_in;
   logic                 change_pending_ff, change_pending_in;
   logic [TimeWidth-1:0] change_time_ff, change_time_in;
   logic [TimeWidth-1:0] press_time_ff, press_time_in;
   mode_type             mode_ff, mode_in;
   bcl_event_type        event_in;

   logic [TimeWidth-1:0] since_change;
   logic [TimeWidth-1:0] since_press;
   logic                 level_changed;
   logic                 debounce_hit;
   logic                 accept_hit;
   logic                 long_hit;

   // Elapsed times wrap modulo 2^32.
   assign since_change  = sample.now_ms - change_time_ff;
   assign since_press   = sample.now_ms - press_time_ff;
   assign level_changed = sample.pin_level != held_level_ff;
   assign debounce_hit  = change_pending_ff &&
                          (since_change > {{(TimeWidth-CfgWidth){1'b0}}, cfg.debounce_ms});
   assign accept_hit    = !level_changed && debounce_hit;
   assign long_hit      = (mode_ff == MODE_DOWN) &&
                          (since_press > {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_press_ms});

   // Next state for the item in the input register.
   always_comb begin
      primed_in         = primed_ff;
      held_level_in     = held_level_ff;
      change_pending_in = change_pending_ff;
      change_time_in    = change_time_ff;
      press_time_in     = press_time_ff;
      mode_in           = mode_ff;
      event_in          = EVENT_NONE;
      if (!primed_ff) begin
         // The first item only captures the pin level.
         primed_in         = 1'b1;
         held_level_in     = sample.pin_level;
         change_pending_in = 1'b0;
      end else begin
         if (level_changed) begin
            held_level_in     = sample.pin_level;
            change_pending_in = 1'b1;
            change_time_in    = sample.now_ms;
         end else if (debounce_hit) begin
            change_pending_in = 1'b0;
         end
         // A stable level is confirmed; the long-press check waits.
         if (accept_hit) begin
            if (held_level_ff == cfg.pressed_level) begin
               mode_in       = MODE_DOWN;
               press_time_in = sample.now_ms;
            end else if (mode_ff == MODE_DOWN) begin
               mode_in  = MODE_CLICK;
               event_in = EVENT_CLICK;
            end else begin
               mode_in = MODE_NONE;
            end
         end else if (long_hit) begin
            mode_in  = MODE_LONG;
            event_in = EVENT_LONG;
         end
      end
   end

   // Detector state advances once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff         <= 1'b0;
         held_level_ff     <= 1'b0;
         change_pending_ff <= 1'b0;
         change_time_ff    <= '0;
         press_time_ff     <= '0;
         mode_ff           <= MODE_NONE;
      end else if (fire) begin
         primed_ff         <= primed_in;
         held_level_ff     <= held_level_in;
         change_pending_ff <= change_pending_in;
         change_time_ff    <= change_time_in;
         press_time_ff     <= press_time_in;
         mode_ff           <= mode_in;
      end
   end

   assign event_code    = event_in;
   assign button_status = mode_in;

endmodule

FILE: hw/rtl/button_click_long_press_detector_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_now_ms[31:0], req_pin_level
// rsp       out        rsp_valid/rsp_stall  rsp_event_code[1:0], rsp_button_status[1:0]
// csr       in         csr_write            csr_index[1:0], csr_wdata[15:0]
//
// One item is accepted per cycle while the result register is free or draining.
// The rate is set by the single pass from the input register through the detector
// into the result register, which holds two 32-bit subtract-and-compare paths.
// Reset is synchronous: it clears detector state and valids, and loads register reset values.
// A stalled result holds the result register and, through it, the input register.
module button_click_long_press_detector_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bcl_pkg::TimeWidth-1:0] req_now_ms,
   input  logic                          req_pin_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_event_code,
   output logic [1:0]                    rsp_button_status,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [bcl_pkg::CfgWidth-1:0]  csr_wdata
);
   import bcl_pkg::*;

   bcl_cfg_type    cfg_ff;
   bcl_sample_type sample;
   logic           sample_valid;
   logic           out_ready;
   logic           fire;
   logic [1:0]     event_code;
   logic [1:0]     button_status;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_event_code_ff;
   logic [1:0]     rsp_button_status_ff;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DebounceReset;
         cfg_ff.long_press_ms <= LongPressReset;
         cfg_ff.pressed_level <= PressedReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE:      cfg_ff.debounce_ms   <= csr_wdata;
            CSR_LONG_PRESS:    cfg_ff.long_press_ms <= csr_wdata;
            CSR_PRESSED_LEVEL: cfg_ff.pressed_level <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The result register can take an item when empty or being drained.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign fire         = sample_valid && out_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   bcl_req_stage u_req_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_now_ms    (req_now_ms),
      .req_pin_level (req_pin_level),
      .req_stall     (req_stall),
      .out_ready     (out_ready),
      .sample_valid  (sample_valid),
      .sample        (sample)
   );

   bcl_detect u_detect (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sample        (sample),
      .cfg           (cfg_ff),
      .event_code    (event_code),
      .button_status (button_status)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_event_code_ff    <= event_code;
         rsp_button_status_ff <= button_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_event_code_ff;
   assign rsp_button_status = rsp_button_status_ff;

endmodule

FILE: bench/tb_button_click_long_press_detector_unit.sv
`timescale 1ns / 100ps

module tb_button_click_long_press_detector_unit;
   import bcl_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 4;
   // Index past the last register; writes to it must be ignored.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_DOWN    = 2'd1,
      MODE_CLICKED = 2'd2,
      MODE_LONG    = 2'd3
   } button_mode_type;

   typedef struct packed {
      bcl_event_type   event_code;
      button_mode_type button_status;
   } button_result_type;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [TimeWidth-1:0] req_now_ms    = '0;
   logic                 req_pin_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [1:0]           rsp_event_code;
   logic [1:0]           rsp_button_status;
   logic                 csr_write     = 1'b0;
   logic [1:0]           csr_index     = '0;
   logic [CfgWidth-1:0]  csr_wdata     = '0;

   // Our own copy of the detector registers and state.
   logic [CfgWidth-1:0]  debounce_cfg    = DebounceReset;
   logic [CfgWidth-1:0]  long_press_cfg  = LongPressReset;
   logic                 pressed_cfg     = PressedReset;
   logic                 seen_first      = 1'b0;
   logic                 last_level      = 1'b0;
   logic                 level_pending   = 1'b0;
   logic [TimeWidth-1:0] level_change_ms = '0;
   logic [TimeWidth-1:0] press_start_ms  = '0;
   button_mode_type      button_mode     = MODE_NONE;

   button_result_type    expected_results[$];
   int                   error_count   = 0;
   int                   cycle_count   = 0;
   int                   items_sent    = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   logic [TimeWidth-1:0] sim_ms        = '0;

   button_click_long_press_detector_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ms        (req_now_ms),
      .req_pin_level     (req_pin_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_button_status (rsp_button_status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_button_click_long_press_detector_unit NOT OK");
         $finish;
      end
   end

   // Debounce the sample, then update the button mode and report its event.
   function automatic button_result_type predict_button_result(logic [TimeWidth-1:0] now,
                                                               logic level);
      button_result_type res;
      logic              accepted;
      accepted       = 1'b0;
      res.event_code = EVENT_NONE;
      if (!seen_first) begin
         seen_first    = 1'b1;
         last_level    = level;
         level_pending = 1'b0;
      end else begin
         if (level != last_level) begin
            last_level      = level;
            level_pending   = 1'b1;
            level_change_ms = now;
         end else if (level_pending &&
                      (now - level_change_ms) > TimeWidth'(debounce_cfg)) begin
            level_pending = 1'b0;
            accepted      = 1'b1;
         end
         // The long-press check is skipped on an item that accepts a level.
         if (accepted) begin
            if (last_level == pressed_cfg) begin
               button_mode    = MODE_DOWN;
               press_start_ms = now;
            end else if (button_mode == MODE_DOWN) begin
               button_mode    = MODE_CLICKED;
               res.event_code = EVENT_CLICK;
            end else begin
               button_mode = MODE_NONE;
            end
         end else if (button_mode == MODE_DOWN &&
                      (now - press_start_ms) > TimeWidth'(long_press_cfg)) begin
            button_mode    = MODE_LONG;
            res.event_code = EVENT_LONG;
         end
      end
      res.button_status = button_mode;
      return res;
   endfunction

   // Receiver side: random stalls, changed at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= (int'($urandom_range(99)) < recv_idle_pct);
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      button_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: event_code %0d, button_status %0d",
                   rsp_event_code, rsp_button_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_event_code != want.event_code) begin
               $error("event_code mismatch: expected %0d, actual %0d",
                      want.event_code, rsp_event_code);
               error_count++;
            end
            if (rsp_button_status != want.button_status) begin
               $error("button_status mismatch: expected %0d, actual %0d",
                      want.button_status, rsp_button_status);
               error_count++;
            end
         end
      end
   end

   // Send one item; called and returning just after a falling edge.
   task automatic send_sample(logic [TimeWidth-1:0] now, logic level);
      if (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_now_ms    <= now;
      req_pin_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_button_result(now, level));
      items_sent++;
      @(negedge clock);
   endtask

   // Move the millisecond clock forward and send a sample at the new time.
   task automatic sample_after(int unsigned step, logic level);
      sim_ms = sim_ms + step;
      send_sample(sim_ms, level);
   endtask

   // Stop sending, then wait until every expected result has come.
   task automatic wait_for_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_register(logic [1:0] index, logic [CfgWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_DEBOUNCE:      debounce_cfg   = value;
         CSR_LONG_PRESS:    long_press_cfg = value;
         CSR_PRESSED_LEVEL: pressed_cfg    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Hold one level for a while, sampling at random intervals.
   task automatic hold_level(logic level, int unsigned span);
      int unsigned held;
      int unsigned step;
      int unsigned step_max;
      held     = 0;
      step_max = (int'(debounce_cfg) + int'(long_press_cfg)) / 8 + 1;
      do begin
         step = $urandom_range(0, step_max);
         held += step;
         sample_after(step, level);
      end while (held <= span);
   endtask

   // A press with contact bounce, a hold of random length and a bouncy release.
   task automatic send_gesture();
      int unsigned deb;
      int unsigned lp;
      deb = debounce_cfg;
      lp  = long_press_cfg;
      repeat ($urandom_range(0, 3)) sample_after($urandom_range(0, deb), 1'($urandom_range(1)));
      hold_level(pressed_cfg, $urandom_range(deb, deb + 2 * lp + 2));
      repeat ($urandom_range(0, 3)) sample_after($urandom_range(0, deb), 1'($urandom_range(1)));
      hold_level(!pressed_cfg, $urandom_range(deb, 2 * deb + 2));
   endtask

   // A single sample with a random level and a random, sometimes huge, time step.
   task automatic send_noise();
      int unsigned step;
      case ($urandom_range(3))
         0:       step = 0;
         1:       step = $urandom_range(0, int'(debounce_cfg) + 1);
         2:       step = $urandom_range(0, int'(long_press_cfg) + 1);
         default: step = $urandom;
      endcase
      sample_after(step, 1'($urandom_range(1)));
   endtask

   // Default registers: clicks, long clicks, re-presses, time wrap; then high pressed level.
   task automatic test_directed_gestures();
      sim_ms = 32'hFFFF_FFFF;
      send_sample(sim_ms, 1'b1);   // first item only captures the level
      sample_after(0, 1'b0);
      sample_after(50, 1'b0);      // exactly the debounce time: not yet stable
      sample_after(1, 1'b0);       // press accepted across the wrap of time
      sample_after(1000, 1'b1);    // exactly the long-press time: no event
      sample_after(1, 1'b0);       // long click on an item that changes level
      sample_after(149, 1'b0);     // press accepted after a long click
      sample_after(10, 1'b1);
      sample_after(51, 1'b1);      // click
      sample_after(9, 1'b0);
      sample_after(51, 1'b0);      // press accepted after a click
      sample_after(9, 1'b1);
      sample_after(10, 1'b0);
      sample_after(51, 1'b0);      // press accepted while down restarts the hold
      sample_after(1000, 1'b0);
      sample_after(1, 1'b0);       // long click
      sample_after(8, 1'b1);
      sample_after(51, 1'b1);      // release while not down goes back to none
      wait_for_results_drained();
      write_register(CSR_UNUSED, '0);
      write_register(CSR_PRESSED_LEVEL, 16'hFFFF);
      sample_after(100, 1'b1);
      sample_after(0, 1'b0);
      sample_after(51, 1'b0);
      sample_after(5, 1'b1);
      sample_after(51, 1'b1);      // press with the high level as pressed
   endtask

   // Both timing registers at zero, then both at their maximum.
   task automatic test_register_extremes();
      wait_for_results_drained();
      write_register(CSR_DEBOUNCE, '0);
      write_register(CSR_LONG_PRESS, '0);
      write_register(CSR_PRESSED_LEVEL, '0);
      sim_ms = 32'h7FFF_FFF0;
      sample_after(0, 1'b0);
      sample_after(0, 1'b0);
      sample_after(1, 1'b0);
      sample_after(0, 1'b0);
      sample_after(1, 1'b0);
      wait_for_results_drained();
      write_register(CSR_DEBOUNCE, 16'hFFFF);
      write_register(CSR_LONG_PRESS, 16'hFFFF);
      sample_after(10, 1'b1);
      sample_after(65535, 1'b1);
      sample_after(1, 1'b1);
      sample_after(1, 1'b0);
      sample_after(65536, 1'b0);
      sample_after(65535, 1'b0);
      sample_after(1, 1'b0);
   endtask

   // Random gestures and noise under one register setting and one idling mix.
   task automatic test_random_traffic(int n_items, int sender_pct, int receiver_pct,
                                      logic [CfgWidth-1:0] deb, logic [CfgWidth-1:0] lp,
                                      logic pressed);
      int stop_at;
      int pause_at;
      bit paused;
      wait_for_results_drained();
      write_register(CSR_DEBOUNCE, deb);
      write_register(CSR_LONG_PRESS, lp);
      write_register(CSR_PRESSED_LEVEL, {{(CfgWidth-1){1'b0}}, pressed});
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sim_ms        = $urandom;
      stop_at       = items_sent + n_items;
      pause_at      = items_sent + n_items / 2;
      paused        = 1'b0;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 25) begin
            send_noise();
         end else begin
            send_gesture();
         end
         // Once per run, hold off until the block has delivered everything.
         if (!paused && items_sent >= pause_at) begin
            paused = 1'b1;
            wait_for_results_drained();
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed_gestures();
      test_register_extremes();
      test_random_traffic(170, 33, 69, 16'($urandom_range(0, 20)),
                          16'($urandom_range(0, 300)), 1'($urandom_range(1)));
      test_random_traffic(170, 69, 33, 16'hFFFF, 16'($urandom_range(0, 500)),
                          1'($urandom_range(1)));
      test_random_traffic(170, 0, 0, 16'($urandom_range(0, 60)), 16'hFFFF,
                          1'($urandom_range(1)));
      wait_for_results_drained();
      if (error_count == 0) begin
         $display("tb_button_click_long_press_detector_unit OK");
      end else begin
         $display("tb_button_click_long_press_detector_unit NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bcl_pkg.sv
hw/rtl/bcl_req_stage.sv
hw/rtl/bcl_detect.sv
hw/rtl/button_click_long_press_detector_unit.sv
bench/tb_button_click_long_press_detector_unit.sv
